// ----- hdl/utf8v_pkg.sv -----
`timescale 1ns / 1ps

package utf8v_pkg;

   localparam int DataWidth     = 8;
   localparam int CountWidth    = 17;
   localparam int LengthWidth   = 16;
   localparam int CodeWidth     = 21;
   localparam int CsrIndexWidth = 8;

   localparam logic [CsrIndexWidth-1:0] RegMaxLength      = 8'd0;
   localparam logic [CsrIndexWidth-1:0] RegAllowMultiline = 8'd1;

   localparam logic [LengthWidth-1:0] MaxLengthReset = 16'd2048;

   localparam logic [DataWidth-1:0] ByteTab     = 8'h09;
   localparam logic [DataWidth-1:0] ByteNewline = 8'h0a;
   localparam logic [DataWidth-1:0] ByteReturn  = 8'h0d;
   localparam logic [DataWidth-1:0] ByteSpace   = 8'h20;
   localparam logic [DataWidth-1:0] ByteDelete  = 8'h7f;
   localparam logic [DataWidth-1:0] ByteLead2Lo = 8'hc2;
   localparam logic [DataWidth-1:0] ByteLead2Hi = 8'hdf;
   localparam logic [DataWidth-1:0] ByteLead3Lo = 8'he0;
   localparam logic [DataWidth-1:0] ByteLead3Hi = 8'hef;
   localparam logic [DataWidth-1:0] ByteLead4Lo = 8'hf0;
   localparam logic [DataWidth-1:0] ByteLead4Hi = 8'hf4;

   localparam logic [CodeWidth-1:0] MinTwoByte   = 21'h000080;
   localparam logic [CodeWidth-1:0] MinThreeByte = 21'h000800;
   localparam logic [CodeWidth-1:0] MinFourByte  = 21'h010000;
   localparam logic [CodeWidth-1:0] MaxScalar    = 21'h10ffff;
   localparam logic [CodeWidth-1:0] SurrogateLo  = 21'h00d800;
   localparam logic [CodeWidth-1:0] SurrogateHi  = 21'h00dfff;

   typedef struct packed {
      logic [DataWidth-1:0] data_byte;
      logic                 has_byte;
      logic                 end_of_text;
   } item_type;

endpackage

// ----- hdl/utf8v_track.sv -----
`timescale 1ns / 1ps

module utf8v_track (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  utf8v_pkg::item_type               item,
   input  logic [utf8v_pkg::LengthWidth-1:0] max_length,
   input  logic                              allow_multiline,
   output logic                              text_ok
);
   import utf8v_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [1:0]            pend_ff, pend_in;
   logic [1:0]            seq_ff, seq_in;
   logic [CodeWidth-1:0]  code_ff, code_in;
   logic                  visible_ff, visible_in;
   logic                  failed_ff, failed_in;

   logic [DataWidth-1:0]  b;
   logic [CountWidth-1:0] count_n;
   logic [1:0]            pend_n, seq_n;
   logic [CodeWidth-1:0]  code_n, code_shift;
   logic                  visible_n, failed_n;
   logic                  ctrl_allowed;
   logic                  bad_scalar;

   always_comb begin
      b          = item.data_byte;
      count_n    = count_ff;
      pend_n     = pend_ff;
      seq_n      = seq_ff;
      code_n     = code_ff;
      visible_n  = visible_ff;
      failed_n   = failed_ff;
      code_shift = {code_ff[CodeWidth-7:0], b[5:0]};
      ctrl_allowed = allow_multiline &&
                     (b == ByteTab || b == ByteNewline || b == ByteReturn);
      bad_scalar = 1'b0;
      if (seq_ff == 2'd1 && code_shift < MinTwoByte) bad_scalar = 1'b1;
      if (seq_ff == 2'd2 && code_shift < MinThreeByte) bad_scalar = 1'b1;
      if (seq_ff == 2'd3 && code_shift < MinFourByte) bad_scalar = 1'b1;
      if (code_shift > MaxScalar) bad_scalar = 1'b1;
      if (code_shift >= SurrogateLo && code_shift <= SurrogateHi) bad_scalar = 1'b1;

      if (item.has_byte) begin
         if (count_ff != {CountWidth{1'b1}}) begin
            count_n = count_ff + 1'b1;
         end
         if (!failed_ff) begin
            if (pend_ff != 2'd0) begin
               if (b[7:6] != 2'b10) begin
                  failed_n = 1'b1;
               end else begin
                  code_n = code_shift;
                  pend_n = pend_ff - 2'd1;
                  if (pend_ff == 2'd1 && bad_scalar) begin
                     failed_n = 1'b1;
                  end
               end
            end else if ((b < ByteSpace && !ctrl_allowed) || b == ByteDelete) begin
               failed_n = 1'b1;
            end else begin
               if (b > ByteSpace) begin
                  visible_n = 1'b1;
               end
               if (b[7]) begin
                  if (b >= ByteLead2Lo && b <= ByteLead2Hi) begin
                     pend_n = 2'd1;
                     seq_n  = 2'd1;
                     code_n = {{(CodeWidth-5){1'b0}}, b[4:0]};
                  end else if (b >= ByteLead3Lo && b <= ByteLead3Hi) begin
                     pend_n = 2'd2;
                     seq_n  = 2'd2;
                     code_n = {{(CodeWidth-4){1'b0}}, b[3:0]};
                  end else if (b >= ByteLead4Lo && b <= ByteLead4Hi) begin
                     pend_n = 2'd3;
                     seq_n  = 2'd3;
                     code_n = {{(CodeWidth-3){1'b0}}, b[2:0]};
                  end else begin
                     failed_n = 1'b1;
                  end
               end
            end
         end
      end

      text_ok = !failed_n && count_n != '0 &&
                count_n <= {1'b0, max_length} && pend_n == 2'd0 && visible_n;

      count_in   = count_ff;
      pend_in    = pend_ff;
      seq_in     = seq_ff;
      code_in    = code_ff;
      visible_in = visible_ff;
      failed_in  = failed_ff;
      if (go) begin
         if (item.end_of_text) begin
            count_in   = '0;
            pend_in    = '0;
            seq_in     = '0;
            code_in    = '0;
            visible_in = 1'b0;
            failed_in  = 1'b0;
         end else begin
            count_in   = count_n;
            pend_in    = pend_n;
            seq_in     = seq_n;
            code_in    = code_n;
            visible_in = visible_n;
            failed_in  = failed_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pend_ff    <= '0;
         seq_ff     <= '0;
         code_ff    <= '0;
         visible_ff <= 1'b0;
         failed_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         seq_ff     <= seq_in;
         code_ff    <= code_in;
         visible_ff <= visible_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

// ----- hdl/utf8_text_validator_core.sv -----
`timescale 1ns / 1ps

// Checks a text that arrives one byte per beat and returns one beat with
// text_ok on the beat that carries end_of_text. A beat is taken into an input
// register; the decode state is updated from it, and for a closing beat the
// verdict lands in an output register as the state updates. The block takes
// one beat per cycle unless a closing beat waits behind a verdict held by rsp_stall.
// The decode state register is the only loop and holds one byte's update.
// Registers may be written only while no beat is in flight.

module utf8_text_validator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [utf8v_pkg::DataWidth-1:0]     req_data_byte,
   input  logic                                req_has_byte,
   input  logic                                req_end_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_text_ok,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [utf8v_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [utf8v_pkg::LengthWidth-1:0]   csr_data
);
   import utf8v_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   item_type               item_ff, item_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_ok_ff, out_ok_in;
   logic [LengthWidth-1:0] max_length_ff, max_length_in;
   logic                   multiline_ff, multiline_in;

   logic out_free;
   logic proc_go;
   logic take_req;
   logic text_ok;

   assign csr_ready = 1'b1;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign proc_go   = in_valid_ff && (!item_ff.end_of_text || out_free);
   assign req_stall = in_valid_ff && !proc_go;
   assign take_req  = req_valid && !req_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_text_ok = out_ok_ff;

   utf8v_track u_track (
      .clock           (clock),
      .reset           (reset),
      .go              (proc_go),
      .item            (item_ff),
      .max_length      (max_length_ff),
      .allow_multiline (multiline_ff),
      .text_ok         (text_ok)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
         item_in     = '{data_byte: req_data_byte, has_byte: req_has_byte,
                         end_of_text: req_end_of_text};
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      if (proc_go && item_ff.end_of_text) begin
         out_valid_in = 1'b1;
         out_ok_in    = text_ok;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      max_length_in = max_length_ff;
      multiline_in  = multiline_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegMaxLength:      max_length_in = csr_data;
            RegAllowMultiline: multiline_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         max_length_ff <= MaxLengthReset;
         multiline_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         max_length_ff <= max_length_in;
         multiline_ff  <= multiline_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      out_ok_ff <= out_ok_in;
   end

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (proc_go && item_ff.end_of_text) |=> rsp_valid)
      else $error("closing beat did not produce a result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && item_ff.end_of_text && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   a_no_result_without_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !(proc_go && item_ff.end_of_text)) |=> !rsp_valid)
      else $error("result appeared without a closing beat");

endmodule

// ----- sim/tb_utf8_text_validator_core.sv -----
`timescale 1ns / 1ps

module tb_utf8_text_validator_core;
   import utf8v_pkg::*;

   localparam logic [CsrIndexWidth-1:0] RegUnused = '1;
   localparam int unsigned CycleLimit = 2_000_000;
   localparam int unsigned RandomBeats = 420;

   typedef struct {
      logic [DataWidth-1:0] data_byte;
      logic                 has_byte;
      logic                 end_of_text;
      bit                   typed;
      logic                 typed_ok;
   } row_type;

   localparam int NumRows = 27;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [DataWidth-1:0] req_data_byte;
   logic req_has_byte;
   logic req_end_of_text;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_text_ok;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [LengthWidth-1:0] csr_data;

   logic [CountWidth-1:0] text_count;
   logic [1:0] trail_left;
   logic [1:0] trail_total;
   logic [CodeWidth-1:0] scalar_acc;
   logic saw_visible;
   logic text_broken;
   logic [LengthWidth-1:0] cfg_max_length;
   logic cfg_multiline;

   logic verdicts_due [$];
   logic expected_ok;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   int unsigned beats_sent = 0;
   int unsigned rsp_hold = 0;
   int unsigned stall_left = 0;
   bit verdict_taken = 1'b0;
   bit idle_on = 1'b1;

   row_type directed_rows [0:NumRows-1] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
      '{8'h20, 1'b1, 1'b1, 1'b1, 1'b0},
      '{8'h7f, 1'b1, 1'b1, 1'b1, 1'b0},
      '{8'hff, 1'b1, 1'b1, 1'b1, 1'b0},
      '{8'h7e, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'haa, 1'b0, 1'b1, 1'b1, 1'b1},
      '{8'hc2, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'ha9, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'he0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hed, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'ha0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hf4, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h90, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hf4, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h8f, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hbf, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hbf, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'he2, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h82, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h09, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h78, 1'b1, 1'b1, 1'b0, 1'b0}
   };

   utf8_text_validator_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_ok     (rsp_text_ok),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic clear_decode();
      text_count  = '0;
      trail_left  = '0;
      trail_total = '0;
      scalar_acc  = '0;
      saw_visible = 1'b0;
      text_broken = 1'b0;
   endtask

   task automatic decode_byte(input logic [DataWidth-1:0] b);
      logic [CodeWidth-1:0] cp;
      logic [1:0] trail;
      if (text_count != '1)
         text_count++;
      if (text_broken)
         return;
      if (trail_left != 0) begin
         if (b[7:6] != 2'b10) begin
            text_broken = 1'b1;
            return;
         end
         cp = {scalar_acc[CodeWidth-7:0], b[5:0]};
         scalar_acc = cp;
         trail_left--;
         if (trail_left == 0) begin
            if ((trail_total == 2'd1 && cp < MinTwoByte) ||
                (trail_total == 2'd2 && cp < MinThreeByte) ||
                (trail_total == 2'd3 && cp < MinFourByte) ||
                cp > MaxScalar || (cp >= SurrogateLo && cp <= SurrogateHi))
               text_broken = 1'b1;
         end
         return;
      end
      if (b < ByteSpace &&
          !(cfg_multiline && (b == ByteTab || b == ByteNewline || b == ByteReturn))) begin
         text_broken = 1'b1;
         return;
      end
      if (b == ByteDelete) begin
         text_broken = 1'b1;
         return;
      end
      if (b > ByteSpace)
         saw_visible = 1'b1;
      if (b[7] == 1'b0)
         return;
      if (b >= ByteLead2Lo && b <= ByteLead2Hi)
         trail = 2'd1;
      else if (b >= ByteLead3Lo && b <= ByteLead3Hi)
         trail = 2'd2;
      else if (b >= ByteLead4Lo && b <= ByteLead4Hi)
         trail = 2'd3;
      else
         trail = 2'd0;
      if (trail == 0) begin
         text_broken = 1'b1;
         return;
      end
      trail_left  = trail;
      trail_total = trail;
      scalar_acc  = CodeWidth'(b & (8'h7f >> trail));
   endtask

   function automatic logic text_verdict();
      return !text_broken && text_count >= 1 && text_count <= cfg_max_length &&
             trail_left == 0 && saw_visible;
   endfunction

   task automatic send_beat(input item_type beat, input bit typed, input logic typed_ok);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= beat.data_byte;
      req_has_byte    <= beat.has_byte;
      req_end_of_text <= beat.end_of_text;
      do @(posedge clock); while (req_stall);
      if (beat.has_byte || beat.end_of_text)
         beats_sent++;
      if (beat.has_byte)
         decode_byte(beat.data_byte);
      if (beat.end_of_text) begin
         verdicts_due.push_back(typed ? typed_ok : text_verdict());
         clear_decode();
      end
   endtask

   task automatic send_text(input item_type text [$]);
      foreach (text[i])
         send_beat(text[i], 1'b0, 1'b0);
   endtask

   task automatic send_filler(input int unsigned length);
      for (int unsigned i = 0; i < length; i++)
         send_beat('{data_byte: 8'h61, has_byte: 1'b1, end_of_text: i == length - 1},
                   1'b0, 1'b0);
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [LengthWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         RegMaxLength:      cfg_max_length = value;
         RegAllowMultiline: cfg_multiline  = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_scalar(ref item_type text [$], input logic [CodeWidth-1:0] cp,
                             input int unsigned width);
      case (width)
         1: text.push_back('{cp[7:0], 1'b1, 1'b0});
         2: begin
            text.push_back('{{3'b110, cp[10:6]}, 1'b1, 1'b0});
            text.push_back('{{2'b10, cp[5:0]}, 1'b1, 1'b0});
         end
         3: begin
            text.push_back('{{4'b1110, cp[15:12]}, 1'b1, 1'b0});
            text.push_back('{{2'b10, cp[11:6]}, 1'b1, 1'b0});
            text.push_back('{{2'b10, cp[5:0]}, 1'b1, 1'b0});
         end
         default: begin
            text.push_back('{{5'b11110, cp[20:18]}, 1'b1, 1'b0});
            text.push_back('{{2'b10, cp[17:12]}, 1'b1, 1'b0});
            text.push_back('{{2'b10, cp[11:6]}, 1'b1, 1'b0});
            text.push_back('{{2'b10, cp[5:0]}, 1'b1, 1'b0});
         end
      endcase
   endtask

   task automatic send_random_text();
      item_type text [$];
      int unsigned chars;
      int unsigned pick;
      int unsigned width;
      chars = $urandom_range(0, 10);
      repeat (chars) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            add_scalar(text, CodeWidth'($urandom_range(33, 126)), 1);
         else if (pick < 50)
            add_scalar(text, CodeWidth'(ByteSpace), 1);
         else if (pick < 56) begin
            case ($urandom_range(0, 2))
               0:       add_scalar(text, CodeWidth'(ByteTab), 1);
               1:       add_scalar(text, CodeWidth'(ByteNewline), 1);
               default: add_scalar(text, CodeWidth'(ByteReturn), 1);
            endcase
         end else if (pick < 70)
            add_scalar(text, CodeWidth'($urandom_range(21'h80, 21'h7ff)), 2);
         else if (pick < 80)
            add_scalar(text, CodeWidth'($urandom_range(21'h800, 21'hffff)), 3);
         else if (pick < 88)
            add_scalar(text, CodeWidth'($urandom_range(21'h10000, 21'h10ffff)), 4);
         else if (pick < 91)
            text.push_back('{8'($urandom), 1'b0, 1'b0});
         else if (pick < 94)
            text.push_back('{8'($urandom), 1'b1, 1'b0});
         else if (pick < 96) begin
            width = $urandom_range(2, 4);
            add_scalar(text, CodeWidth'($urandom_range(0, width == 2 ? 21'h7f :
                                        width == 3 ? 21'h7ff : 21'hffff)), width);
         end else if (pick < 98) begin
            add_scalar(text, CodeWidth'($urandom_range(21'h10000, 21'h10ffff)), 4);
            repeat ($urandom_range(1, 3)) void'(text.pop_back());
         end else
            add_scalar(text, CodeWidth'($urandom_range(21'h110000, 21'h1fffff)), 4);
      end
      if (text.size() != 0 && $urandom_range(0, 1) == 1)
         text[text.size() - 1].end_of_text = 1'b1;
      else
         text.push_back('{8'($urandom), 1'b0, 1'b1});
      send_text(text);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (verdict_taken) begin
            verdict_taken = 1'b0;
            stall_left = idle_on ? $urandom_range(0, 7) : 0;
         end
         if (rsp_hold != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         verdict_taken = 1'b1;
         if (verdicts_due.size() == 0) begin
            $error("text_ok beat with no verdict pending: actual %0b", rsp_text_ok);
            failures++;
         end else begin
            expected_ok = verdicts_due.pop_front();
            if (rsp_text_ok !== expected_ok) begin
               $error("text_ok mismatch: expected %0b, actual %0b", expected_ok, rsp_text_ok);
               failures++;
            end
         end
      end
   end

   initial begin
      item_type text [$];
      logic [LengthWidth-1:0] length_cap;
      int unsigned phase;
      int unsigned phase_goal;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = '0;
      req_has_byte    = 1'b0;
      req_end_of_text = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      cfg_max_length  = MaxLengthReset;
      cfg_multiline   = 1'b0;
      clear_decode();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat('{directed_rows[i].data_byte, directed_rows[i].has_byte,
                     directed_rows[i].end_of_text},
                   directed_rows[i].typed, directed_rows[i].typed_ok);
      drain_block();

      write_reg(RegUnused, 16'hffff);
      write_reg(RegAllowMultiline, 16'hffff);
      text = '{'{ByteTab, 1'b1, 1'b0}, '{ByteNewline, 1'b1, 1'b0},
               '{ByteReturn, 1'b1, 1'b0}, '{8'h41, 1'b1, 1'b1},
               '{ByteNewline, 1'b1, 1'b1}};
      send_text(text);
      drain_block();

      write_reg(RegMaxLength, 16'd1);
      text = '{'{8'h41, 1'b1, 1'b1}, '{8'h41, 1'b1, 1'b0}, '{8'h42, 1'b1, 1'b1}};
      send_text(text);
      drain_block();

      write_reg(RegMaxLength, 16'd0);
      text = '{'{8'h41, 1'b1, 1'b1}, '{8'h20, 1'b0, 1'b1}};
      send_text(text);
      drain_block();

      // Texts at the length limit and one past it.
      write_reg(RegMaxLength, 16'd6);
      write_reg(RegAllowMultiline, 16'h0000);
      idle_on = 1'b0;
      send_filler(6);
      send_filler(7);
      drain_block();

      phase = 0;
      phase_goal = beats_sent + RandomBeats;
      while (beats_sent < phase_goal) begin
         case ($urandom_range(0, 7))
            0:       length_cap = 16'd0;
            1:       length_cap = 16'd1;
            2:       length_cap = 16'hffff;
            3:       length_cap = 16'($urandom);
            4:       length_cap = MaxLengthReset;
            default: length_cap = 16'($urandom_range(4, 40));
         endcase
         write_reg(RegMaxLength, length_cap);
         write_reg(RegAllowMultiline, {15'($urandom), 1'($urandom)});
         if (phase == 2) begin
            idle_on = 1'b0;
            rsp_hold = 200;
            repeat (40) send_beat('{8'h5a, 1'b1, 1'b1}, 1'b0, 1'b0);
            drain_block();
         end
         idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(4, 9)) send_random_text();
         drain_block();
         phase++;
      end

      drain_block();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
